>>> hdl/utf8_byte_sanitizer_unit_defines.svh
// Assertion macros shared by the sanitizer RTL.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef UTF8_BYTE_SANITIZER_UNIT_DEFINES_SVH
`define UTF8_BYTE_SANITIZER_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define USBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define USBS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/usbs_pkg.sv
// Shared types and constants for the UTF-8 byte sanitizer.
// No dependencies.
`default_nettype none

package usbs_pkg;

	localparam int QDepth = 8;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// lead and continuation byte tags, compared against the top bits of a byte
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;
	localparam logic [1:0] CONT_TAG  = 2'b10;

	// one group of results caused by a single input item
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [1:0]      last_idx;
		logic            present;
		logic            fin;
	} usbs_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} usbs_qstat_t;

endpackage

`default_nettype wire

>>> hdl/usbs_front.sv
// Front end: accepts bytes, tracks the sequence being gathered and builds result groups.
// Depends on usbs_pkg.
`default_nettype none

module usbs_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           in_byte,
	input  wire logic                 in_final,
	input  wire usbs_pkg::usbs_qstat_t qstat,
	output logic                      push,
	output usbs_pkg::usbs_entry_t     entry
);
	import usbs_pkg::*;

	logic [7:0] held_bytes_q [3];
	logic [1:0] held_count_q;
	logic [2:0] seq_len_q;

	logic       accept;
	logic       is_cont;
	logic       held_act;
	logic [2:0] lead_len;
	logic [2:0] n_res;
	logic [1:0] count_d;
	logic [2:0] len_d;
	logic       wr_held;
	logic [1:0] wr_idx;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		priority if (in_byte[7:5] == LEAD2_TAG) lead_len = 3'd2;
		else if (in_byte[7:4] == LEAD3_TAG) lead_len = 3'd3;
		else if (in_byte[7:3] == LEAD4_TAG) lead_len = 3'd4;
		else lead_len = 3'd0;
	end

	always_comb begin
		is_cont       = (in_byte[7:6] == CONT_TAG);
		held_act      = (held_count_q != 2'd0);
		n_res         = 3'd0;
		count_d       = held_count_q;
		len_d         = seq_len_q;
		wr_held       = 1'b0;
		wr_idx        = 2'd0;
		entry.present = 1'b1;
		entry.fin     = in_final;
		for (int i = 0; i < 4; i++) begin
			entry.data[i] = in_byte;
		end

		if (held_act && is_cont) begin
			if ({1'b0, held_count_q} + 3'd1 == seq_len_q) begin
				// sequence complete: held bytes then this one
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < held_count_q) begin
						entry.data[i] = held_bytes_q[i];
					end
				end
				n_res   = {1'b0, held_count_q} + 3'd1;
				count_d = 2'd0;
				len_d   = 3'd0;
			end else begin
				wr_held = 1'b1;
				wr_idx  = held_count_q;
				count_d = held_count_q + 2'd1;
			end
		end else begin
			// nothing held, or an early non-continuation drops what was held
			count_d = 2'd0;
			len_d   = lead_len;
			if (!in_byte[7]) begin
				n_res = 3'd1;
			end else if (lead_len != 3'd0) begin
				wr_held = 1'b1;
				count_d = 2'd1;
			end
		end

		if (in_final) begin
			count_d = 2'd0;
			len_d   = 3'd0;
			if (n_res == 3'd0) begin
				n_res         = 3'd1;
				entry.present = 1'b0;
				entry.data[0] = 8'h00;
			end
		end

		entry.last_idx = 2'(n_res - 3'd1);
		push           = accept && (n_res != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
			seq_len_q    <= 3'd0;
		end else if (accept) begin
			held_count_q <= count_d;
			seq_len_q    <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_held) begin
			held_bytes_q[wr_idx] <= in_byte;
		end
	end

endmodule

`default_nettype wire

>>> hdl/usbs_queue.sv
// Short FIFO of result groups between the front and back ends.
// Depends on usbs_pkg.
`default_nettype none

module usbs_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire usbs_pkg::usbs_entry_t  wr_entry,
	input  wire logic                  pop,
	output usbs_pkg::usbs_entry_t       head,
	output usbs_pkg::usbs_qstat_t       qstat
);
	import usbs_pkg::*;

	usbs_entry_t      slots_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] fill_q;

	assign qstat.full  = (fill_q == QCntW'(QDepth));
	assign qstat.empty = (fill_q == '0);
	assign head        = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + QCntW'(1);
				2'b01:   fill_q <= fill_q - QCntW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

`default_nettype wire

>>> hdl/usbs_back.sv
// Back end: walks each queued group and sends its bytes one item per cycle while out_ready allows.
// Depends on usbs_pkg.
`default_nettype none

module usbs_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire usbs_pkg::usbs_entry_t  head,
	input  wire usbs_pkg::usbs_qstat_t  qstat,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_byte,
	output logic                       byte_present,
	output logic                       run_end,
	output logic                       stream_end
);
	import usbs_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       present_q;
	logic       run_end_q;
	logic       stream_end_q;
	logic       load;
	logic       last;

	assign load = !qstat.empty && (!out_valid_q || out_ready);
	assign last = (idx_q == head.last_idx);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= head.data[idx_q];
			present_q    <= head.present;
			run_end_q    <= last;
			stream_end_q <= last && head.fin;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign byte_present = present_q;
	assign run_end      = run_end_q;
	assign stream_end   = stream_end_q;

endmodule

`default_nettype wire

>>> hdl/utf8_byte_sanitizer_unit.sv
// UTF-8 byte sanitizer, a byte stream in valid/ready form in and out. The
// front end takes one input item every cycle while the eight-group queue has
// room, and the back end sends one result item every cycle from its output
// register while out_ready holds, so a sustained stream runs at one byte per
// cycle. A completed n-byte sequence leaves as n items from the back end; the
// first result item is written to a queue slot and then to the back end's
// output register before it is valid. Bytes of an unfinished sequence give
// nothing until it completes. The input stalls only when eight groups wait in
// the queue, which takes a stalled output.
// Depends on usbs_pkg, usbs_front, usbs_queue, usbs_back and the defines header.
`default_nettype none

`include "utf8_byte_sanitizer_unit_defines.svh"

module utf8_byte_sanitizer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_final,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            byte_present,
	output logic            run_end,
	output logic            stream_end
);
	import usbs_pkg::*;

	usbs_entry_t wr_entry;
	usbs_entry_t head;
	usbs_qstat_t qstat;
	logic        push;
	logic        pop;

	usbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_final (in_final),
		.qstat    (qstat),
		.push     (push),
		.entry    (wr_entry)
	);

	usbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	usbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.run_end      (run_end),
		.stream_end   (stream_end)
	);

	`USBS_ASSERT(a_no_push_full, push |-> !qstat.full, "group pushed into a full queue")
	`USBS_ASSERT(a_no_pop_empty, pop |-> !qstat.empty, "group popped from an empty queue")
	`USBS_ASSERT(a_stream_end_run, (out_valid && stream_end) |-> run_end, "stream end not on run end")
	`USBS_ASSERT(a_empty_marker,
		(out_valid && !byte_present) |-> (stream_end && out_byte == 8'h00),
		"empty item is not a clean end marker")

endmodule

`default_nettype wire
